### rtl/core/lpd_pkg.sv
`default_nettype none

package lpd_pkg;

    localparam int LEN_BITS     = 20;
    localparam int HEADER_BYTES = 8;
    localparam int FIELD_BITS   = 32;
    localparam int PAY_CFG_BITS = 20;
    localparam int SHIFT_BITS   = 8 * (HEADER_BYTES - 1);

    localparam logic [2:0] HDR_LAST = 3'(HEADER_BYTES - 1);
    localparam logic [FIELD_BITS:0] LEN_MASK =
        (33'd1 << LEN_BITS) - 33'd1;

    localparam logic [FIELD_BITS-1:0]   MIN_TYPE_RST    = 32'd0;
    localparam logic [FIELD_BITS-1:0]   MAX_TYPE_RST    = 32'd15;
    localparam logic [PAY_CFG_BITS-1:0] MAX_PAYLOAD_RST = 20'd65536;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MIN_TYPE    = 2'd0;
    localparam t_cfg_idx CFG_MAX_TYPE    = 2'd1;
    localparam t_cfg_idx CFG_MAX_PAYLOAD = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALTED  = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        K_HDR_BYTE = 3'd0,
        K_HDR_OK   = 3'd1,
        K_PAYLOAD  = 3'd2,
        K_INVALID  = 3'd3,
        K_HALTED   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [FIELD_BITS-1:0] msg_type;
        logic [FIELD_BITS-1:0] payload_len;
        logic [7:0]            payload_byte;
        logic                  last;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/lpd_parse.sv
`default_nettype none

module lpd_parse (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic [7:0]                     i_data_byte,
    input  wire logic                           i_cfg_we,
    input  wire lpd_pkg::t_cfg_idx              i_cfg_idx,
    input  wire logic [lpd_pkg::FIELD_BITS-1:0] i_cfg_data,
    output lpd_pkg::t_result                    o_result
);
    import lpd_pkg::*;

    t_phase                  r_phase, n_phase;
    logic [SHIFT_BITS-1:0]   r_shift, n_shift;
    logic [2:0]              r_count, n_count;
    logic [LEN_BITS-1:0]     r_left, n_left;
    logic [FIELD_BITS-1:0]   r_held, n_held;
    logic [FIELD_BITS-1:0]   r_min_type;
    logic [FIELD_BITS-1:0]   r_max_type;
    logic [PAY_CFG_BITS-1:0] r_max_payload;

    logic [SHIFT_BITS+7:0] shift_full;
    logic [FIELD_BITS-1:0] hdr_type;
    logic [FIELD_BITS-1:0] hdr_len;
    logic                  hdr_ok;
    logic [LEN_BITS-1:0]   left_dec;
    logic                  left_zero;

    assign shift_full = {r_shift, i_data_byte};
    assign hdr_type   = shift_full[2*FIELD_BITS-1:FIELD_BITS];
    assign hdr_len    = shift_full[FIELD_BITS-1:0];
    assign hdr_ok     = (hdr_type >= r_min_type) && (hdr_type <= r_max_type)
                     && (hdr_len <= FIELD_BITS'(r_max_payload))
                     && ({1'b0, hdr_len} <= LEN_MASK);
    assign left_dec   = r_left - LEN_BITS'(1);
    assign left_zero  = (left_dec == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_type    <= MIN_TYPE_RST;
            r_max_type    <= MAX_TYPE_RST;
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_TYPE:    r_min_type    <= i_cfg_data;
                CFG_MAX_TYPE:    r_max_type    <= i_cfg_data;
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[PAY_CFG_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_shift = r_shift;
        n_count = r_count;
        n_left  = r_left;
        n_held  = r_held;
        case (r_phase)
            PH_HEADER: begin
                if (r_count != HDR_LAST) begin
                    n_shift = shift_full[SHIFT_BITS-1:0];
                    n_count = r_count + 3'd1;
                end else begin
                    n_shift = '0;
                    n_count = '0;
                    if (!hdr_ok) begin
                        n_phase = PH_HALTED;
                    end else if (hdr_len != '0) begin
                        n_held  = hdr_type;
                        n_left  = hdr_len[LEN_BITS-1:0];
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_left = left_dec;
                if (left_zero) begin
                    n_phase = PH_HEADER;
                    n_held  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result = '{kind: K_HALTED, msg_type: '0, payload_len: '0,
                     payload_byte: '0, last: 1'b0};
        case (r_phase)
            PH_HEADER: begin
                if (r_count != HDR_LAST) begin
                    o_result.kind = K_HDR_BYTE;
                end else if (!hdr_ok) begin
                    o_result.kind        = K_INVALID;
                    o_result.payload_len = hdr_len;
                end else begin
                    o_result.kind        = K_HDR_OK;
                    o_result.msg_type    = hdr_type;
                    o_result.payload_len = hdr_len;
                    o_result.last        = (hdr_len == '0);
                end
            end
            PH_PAYLOAD: begin
                o_result.kind         = K_PAYLOAD;
                o_result.msg_type     = r_held;
                o_result.payload_byte = i_data_byte;
                o_result.last         = left_zero;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_shift <= '0;
            r_count <= '0;
            r_left  <= '0;
            r_held  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_count <= n_count;
            r_left  <= n_left;
            r_held  <= n_held;
        end
    end

endmodule

`default_nettype wire

### rtl/core/lpd_skid.sv
`default_nettype none

module lpd_skid (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire lpd_pkg::t_result i_result,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output lpd_pkg::t_result      o_result
);
    import lpd_pkg::*;

    t_result    r_buf [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    logic       pop;

    assign o_stall  = (r_cnt == 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign o_result = r_buf[r_rd_ptr];
    assign push     = i_valid && !o_stall;
    assign pop      = o_valid && !i_stall;

    always_comb begin
        n_wr_ptr = push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop  ? !r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    // hold result words, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

endmodule

`default_nettype wire

### rtl/core/length_prefixed_deframer_top.sv
// Length-prefixed deframer: type/length header with payload pass-through.
// Input channel: one stream byte per word on i_data_byte, taken when
// i_valid is high and o_stall is low. Each 8-byte header is a big-endian
// 32-bit type followed by a big-endian 32-bit length.
// Output channel: one result word per input word (o_kind, o_msg_type,
// o_payload_len, o_payload_byte, o_last), taken when o_valid is high and
// i_stall is low.
// Timing: a result is valid in the cycle after its byte is taken. One byte
// per cycle while o_stall is low; the parse logic sits in a single stage
// between the header/count registers and a two-word output buffer.
// Stall: the two-word buffer absorbs a stall; o_stall rises only once both
// words are waiting, and no word is lost or repeated.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 min type, 1 max type, 2 max payload); write only while idle.
// Reset (synchronous, i_rst_n low): header collection restarts, the
// buffer empties, registers return to 0, 15 and 65536. An invalid header
// halts the block until the next reset.
`default_nettype none

module length_prefixed_deframer_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [7:0]                     i_data_byte,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [2:0]                          o_kind,
    output logic [lpd_pkg::FIELD_BITS-1:0]      o_msg_type,
    output logic [lpd_pkg::FIELD_BITS-1:0]      o_payload_len,
    output logic [7:0]                          o_payload_byte,
    output logic                                o_last,
    input  wire logic                           i_cfg_we,
    input  wire lpd_pkg::t_cfg_idx              i_cfg_idx,
    input  wire logic [lpd_pkg::FIELD_BITS-1:0] i_cfg_data
);
    import lpd_pkg::*;

    t_result parse_res;
    t_result out_res;
    logic    in_accept;

    assign in_accept = i_valid && !o_stall;

    lpd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_result    (parse_res)
    );

    lpd_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_result (parse_res),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_res)
    );

    assign o_kind         = out_res.kind;
    assign o_msg_type     = out_res.msg_type;
    assign o_payload_len  = out_res.payload_len;
    assign o_payload_byte = out_res.payload_byte;
    assign o_last         = out_res.last;

`ifndef SYNTH
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted byte produced no result word");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output buffer");

    a_halted_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == K_HALTED) |->
            (o_msg_type == '0 && o_payload_len == '0 && !o_last))
        else $error("halted word carries nonzero fields");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_kind == K_HDR_OK || o_kind == K_PAYLOAD))
        else $error("last flag on a word that cannot end a packet");
`endif

endmodule

`default_nettype wire
